>>> rtl/slft_pkg.sv
// ----------------------------------------------------------------------------
// slft_pkg
// Shared types and constants for the sized literal to four-state converter.
// ----------------------------------------------------------------------------
`default_nettype none

package slft_pkg;

  localparam int MAX_WIDTH_DEF = 64;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_QMARK      = 8'h3F;
  localparam logic [7:0] CH_X          = 8'h78;
  localparam logic [7:0] CH_Z          = 8'h7A;
  localparam logic [7:0] CH_0          = 8'h30;
  localparam logic [7:0] CH_9          = 8'h39;
  localparam logic [7:0] CH_LA         = 8'h61;
  localparam logic [7:0] CH_LF         = 8'h66;
  localparam logic [7:0] CH_UA         = 8'h41;
  localparam logic [7:0] CH_UZ         = 8'h5A;
  localparam logic [7:0] CASE_OFFSET   = 8'd32;

  localparam logic [4:0] DIGIT_NONE = 5'd16;
  localparam logic [4:0] DEC_MAX    = 5'd9;

  localparam logic [6:0] BITS_SAT     = 7'd127;
  localparam logic [1:0] CNT_SAT      = 2'd2;
  localparam logic [6:0] TW_RESET     = 7'd32;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  typedef enum logic [1:0] {
    KIND_KNOWN = 2'd0,
    KIND_X     = 2'd1,
    KIND_Z     = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic {
    REG_RADIX = 1'b0,
    REG_WIDTH = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic       skip;
    kind_t      kind;
    logic [4:0] dv;
  } char_info_t;

  typedef struct packed {
    logic [6:0] bits;
    kind_t      lead;
    logic [1:0] cnt;
    logic       err;
    kind_t      fill;
  } acc_status_t;

endpackage

`default_nettype wire

>>> rtl/slft_decode.sv
// ----------------------------------------------------------------------------
// slft_decode
// Classifies one character: separator, x/z kind and digit value.
// ----------------------------------------------------------------------------
`default_nettype none

module slft_decode (
  input  wire logic [7:0]          char_code,
  output slft_pkg::char_info_t     info
);

  logic [7:0] c;

  always_comb begin
    c = char_code;
    if (char_code >= slft_pkg::CH_UA && char_code <= slft_pkg::CH_UZ) begin
      c = char_code + slft_pkg::CASE_OFFSET;
    end
    info.skip = (char_code == slft_pkg::CH_UNDERSCORE);
    if (c == slft_pkg::CH_X) begin
      info.kind = slft_pkg::KIND_X;
    end else if (c == slft_pkg::CH_Z || c == slft_pkg::CH_QMARK) begin
      info.kind = slft_pkg::KIND_Z;
    end else begin
      info.kind = slft_pkg::KIND_KNOWN;
    end
    if (c >= slft_pkg::CH_0 && c <= slft_pkg::CH_9) begin
      info.dv = 5'(c - slft_pkg::CH_0);
    end else if (c >= slft_pkg::CH_LA && c <= slft_pkg::CH_LF) begin
      info.dv = 5'(c - slft_pkg::CH_LA) + 5'd10;
    end else begin
      info.dv = slft_pkg::DIGIT_NONE;
    end
  end

endmodule

`default_nettype wire

>>> rtl/slft_accum.sv
// ----------------------------------------------------------------------------
// slft_accum
// Literal accumulator: value/unknown planes and digit bookkeeping.
// ----------------------------------------------------------------------------
`default_nettype none

module slft_accum #(
  parameter int MAX_WIDTH = slft_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   adv,
  input  wire logic                   fin,
  input  wire slft_pkg::char_info_t   info,
  input  wire slft_pkg::radix_t       radix,
  output logic [MAX_WIDTH-1:0]        upd_value,
  output logic [MAX_WIDTH-1:0]        upd_unknown,
  output slft_pkg::acc_status_t       upd_status
);

  logic [MAX_WIDTH-1:0]  value_r, unknown_r;
  slft_pkg::acc_status_t status_r;
  logic [2:0]            bpd;
  logic [3:0]            dm;
  logic [4:0]            lim;
  logic [7:0]            bits_sum;
  logic                  took;

  always_comb begin
    unique case (radix)
      slft_pkg::RADIX_BIN: bpd = 3'd1;
      slft_pkg::RADIX_OCT: bpd = 3'd3;
      default:             bpd = 3'd4;
    endcase
    dm  = 4'(~(4'hF << bpd));
    lim = 5'(5'd1 << bpd);
  end

  always_comb begin
    upd_value   = value_r;
    upd_unknown = unknown_r;
    upd_status  = status_r;
    took        = 1'b0;
    bits_sum    = 8'(status_r.bits) + 8'(bpd);
    if (!info.skip) begin
      if (radix == slft_pkg::RADIX_DEC) begin
        if (status_r.cnt == 2'd0) begin
          upd_status.fill = info.kind;
        end
        if (info.dv > slft_pkg::DEC_MAX) begin
          upd_status.err = 1'b1;
        end else begin
          // x*10 as x*8 + x*2
          upd_value = (value_r << 3) + (value_r << 1) + MAX_WIDTH'(info.dv);
        end
      end else begin
        if (info.kind != slft_pkg::KIND_KNOWN) begin
          took        = 1'b1;
          upd_value   = (value_r << bpd) |
                        ((info.kind == slft_pkg::KIND_X) ? MAX_WIDTH'(dm) : '0);
          upd_unknown = (unknown_r << bpd) | MAX_WIDTH'(dm);
        end else if (info.dv < lim) begin
          took        = 1'b1;
          upd_value   = (value_r << bpd) | MAX_WIDTH'(info.dv);
          upd_unknown = unknown_r << bpd;
        end else begin
          upd_status.err = 1'b1;
        end
        if (took) begin
          if (status_r.cnt == 2'd0) begin
            upd_status.lead = info.kind;
          end
          upd_status.bits = (bits_sum > 8'(slft_pkg::BITS_SAT)) ?
                            slft_pkg::BITS_SAT : bits_sum[6:0];
        end
      end
      if (status_r.cnt < slft_pkg::CNT_SAT) begin
        upd_status.cnt = status_r.cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r   <= '0;
      unknown_r <= '0;
      status_r  <= '0;
    end else if (adv) begin
      if (fin) begin
        value_r   <= '0;
        unknown_r <= '0;
        status_r  <= '0;
      end else begin
        value_r   <= upd_value;
        unknown_r <= upd_unknown;
        status_r  <= upd_status;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/slft_result.sv
// ----------------------------------------------------------------------------
// slft_result
// Final formatting (width mask, padding, error) and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module slft_result #(
  parameter int MAX_WIDTH = slft_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   load,
  input  wire logic                   take,
  input  wire slft_pkg::radix_t       radix,
  input  wire logic [6:0]             target_width,
  input  wire logic [MAX_WIDTH-1:0]   acc_value,
  input  wire logic [MAX_WIDTH-1:0]   acc_unknown,
  input  wire slft_pkg::acc_status_t  status,
  output logic                        res_valid,
  output logic                        res_free,
  output logic [MAX_WIDTH-1:0]        value_plane,
  output logic [MAX_WIDTH-1:0]        unknown_plane,
  output logic                        has_unknown,
  output logic                        bad_literal
);

  localparam logic [MAX_WIDTH-1:0] ALL_ONES = '1;
  localparam logic [6:0]           MAX_W7   = 7'(MAX_WIDTH);

  logic [6:0]           w;
  logic [MAX_WIDTH-1:0] m, pad, v, u;
  logic                 bad;
  logic                 valid_r, valid_nxt;
  logic [MAX_WIDTH-1:0] value_r, unknown_r;
  logic                 has_r, bad_r;

  always_comb begin
    w = target_width;
    if (w == 7'd0) begin
      w = 7'd1;
    end
    if (w > MAX_W7) begin
      w = MAX_W7;
    end
    m   = ~(ALL_ONES << w);
    pad = m & (ALL_ONES << status.bits);
    v   = '0;
    u   = '0;
    bad = 1'b0;
    if (status.cnt == 2'd0) begin
      bad = 1'b1;
    end else if (radix == slft_pkg::RADIX_DEC) begin
      if (status.cnt == 2'd1 && status.fill != slft_pkg::KIND_KNOWN) begin
        u = m;
        v = (status.fill == slft_pkg::KIND_X) ? m : '0;
      end else if (status.err) begin
        bad = 1'b1;
      end else begin
        v = acc_value & m;
      end
    end else if (status.err || status.bits == 7'd0) begin
      bad = 1'b1;
    end else begin
      v = acc_value & m;
      u = acc_unknown & m;
      // short literal: extend with the kind of its first digit
      if (status.lead == slft_pkg::KIND_X) begin
        v = v | pad;
        u = u | pad;
      end else if (status.lead == slft_pkg::KIND_Z) begin
        u = u | pad;
      end
    end
  end

  assign res_free  = !valid_r || take;
  assign valid_nxt = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r   <= v;
      unknown_r <= u;
      has_r     <= (u != '0);
      bad_r     <= bad;
    end
  end

  assign res_valid     = valid_r;
  assign value_plane   = value_r;
  assign unknown_plane = unknown_r;
  assign has_unknown   = has_r;
  assign bad_literal   = bad_r;

endmodule

`default_nettype wire

>>> rtl/sized_literal_to_four_state.sv
// ----------------------------------------------------------------------------
// sized_literal_to_four_state
// Builds a four-state value from the digit characters of a sized literal.
// ----------------------------------------------------------------------------
//  channel | dir | signals                        | payload
//  in_     | in  | in_tvalid/tready/tdata/tlast   | tdata: char_code; tlast: is_final
//  out_    | out | out_tvalid/tready/tdata        | tdata: value, unknown, has_unk, bad
//  cfg_    | in  | cfg_we/cfg_index/cfg_wdata     | 0 radix_mode, 1 target_width
//
//  One character per cycle unless stalled; an item is held in the input register
//  and its result (final character only) is loaded into the output register as it advances.
//  Stalls only when a final character waits on a full output register.
//  Reset: synchronous, active low; radix hex, width 32, accumulator empty.
// ----------------------------------------------------------------------------
`default_nettype none

module sized_literal_to_four_state #(
  parameter  int MAX_WIDTH = slft_pkg::MAX_WIDTH_DEF,
  localparam int OutW      = ((2 * MAX_WIDTH + 2 + 7) / 8) * 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [7:0]      in_tdata,    // [7:0] char_code
  input  wire logic            in_tlast,    // is_final
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [OutW-1:0]      out_tdata,   // value_plane, unknown_plane,
                                            // has_unknown, bad_literal, zero fill
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [6:0]      cfg_wdata
);

  slft_pkg::radix_t      radix_r;
  logic [6:0]            width_r;
  logic                  s1_valid_r, s1_fin_r;
  logic [7:0]            s1_char_r;
  logic                  s1_adv, res_free, res_valid;
  slft_pkg::char_info_t  info;
  slft_pkg::acc_status_t upd_status;
  logic [MAX_WIDTH-1:0]  upd_value, upd_unknown, v_plane, u_plane;
  logic                  has_unk, bad_lit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= slft_pkg::RADIX_HEX;
      width_r <= slft_pkg::TW_RESET;
    end else if (cfg_we) begin
      unique case (slft_pkg::reg_idx_t'(cfg_index))
        slft_pkg::REG_RADIX: radix_r <= slft_pkg::radix_t'(cfg_wdata[1:0]);
        slft_pkg::REG_WIDTH: width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s1_adv    = s1_valid_r && (!s1_fin_r || res_free);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
      s1_fin_r  <= in_tlast;
    end
  end

  slft_decode u_decode (
    .char_code (s1_char_r),
    .info      (info)
  );

  slft_accum #(.MAX_WIDTH(MAX_WIDTH)) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (s1_adv),
    .fin         (s1_fin_r),
    .info        (info),
    .radix       (radix_r),
    .upd_value   (upd_value),
    .upd_unknown (upd_unknown),
    .upd_status  (upd_status)
  );

  slft_result #(.MAX_WIDTH(MAX_WIDTH)) u_result (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (s1_adv && s1_fin_r),
    .take          (out_tready),
    .radix         (radix_r),
    .target_width  (width_r),
    .acc_value     (upd_value),
    .acc_unknown   (upd_unknown),
    .status        (upd_status),
    .res_valid     (res_valid),
    .res_free      (res_free),
    .value_plane   (v_plane),
    .unknown_plane (u_plane),
    .has_unknown   (has_unk),
    .bad_literal   (bad_lit)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = OutW'({bad_lit, has_unk, u_plane, v_plane});

  // input side stalls only behind a final character
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_fin_r && out_tvalid && !out_tready))
    else $error("input stalled without a blocked final character");

  a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_fin_r) |=> out_tvalid)
    else $error("final character produced no result");

  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && bad_lit) |-> (v_plane == '0 && u_plane == '0 && !has_unk))
    else $error("bad literal with nonzero planes");

  a_has_unk: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (has_unk == (u_plane != '0)))
    else $error("unknown flag disagrees with unknown plane");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sized literal to four-state converter. A short
// table of literals and register writes comes first, then random literals
// under many radix/width settings, with random stalls on both streams. Each
// final result is checked against an in-bench predictor or a typed table row.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int OUT_W     = ((2 * slft_pkg::MAX_WIDTH_DEF + 2 + 7) / 8) * 8;
  localparam int LIMIT     = 600000;
  localparam int N_PHASES  = 12;
  localparam int PHASE_LEN = 105;

  typedef struct packed {
    logic [63:0] vplane;
    logic [63:0] uplane;
    logic        has_unk;
    logic        bad;
  } lit_res_t;

  typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [7:0]         ch;
    logic               last;
    bit                 typed;
    lit_res_t           res;
    slft_pkg::reg_idx_t idx;
    logic [6:0]         wdata;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [7:0]       in_tdata;
  logic             in_tlast;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_we;
  logic             cfg_index;
  logic [6:0]       cfg_wdata;

  // expectation that travels with the current request (typed table rows)
  bit               drv_typed;
  lit_res_t         drv_res;

  lit_res_t         lit_q[$];
  stim_row_t        dir_rows[$];
  int               err_count = 0;
  int               items_sent;
  int               cycles = 0;

  // predictor state
  slft_pkg::radix_t radix_cfg;
  logic [6:0]       width_cfg;
  logic [63:0]      acc_v;
  logic [63:0]      acc_u;
  int               nbits;
  slft_pkg::kind_t  lead_kind;
  int               ndigits;
  bit               saw_bad;
  slft_pkg::kind_t  dec_fill;

  sized_literal_to_four_state dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("sized_literal_to_four_state verification failed");
      $finish;
    end
  end

  function automatic logic [63:0] lowmask(input int n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic lit_res_t mk_res(input logic [63:0] v, input logic [63:0] u,
                                      input logic h, input logic b);
    lit_res_t r;
    r.vplane  = v;
    r.uplane  = u;
    r.has_unk = h;
    r.bad     = b;
    return r;
  endfunction

  task automatic clear_acc();
    acc_v     = '0;
    acc_u     = '0;
    nbits     = 0;
    lead_kind = slft_pkg::KIND_KNOWN;
    ndigits   = 0;
    saw_bad   = 1'b0;
    dec_fill  = slft_pkg::KIND_KNOWN;
  endtask

  task automatic predict_char(input logic [7:0] ch, input logic fin,
                              output bit got, output lit_res_t r);
    logic [7:0]      c;
    slft_pkg::kind_t k;
    int              dv;
    int              bpd;
    int              w;
    bit              took;
    bit              bad;
    logic [63:0]     dm, m, v, u, pad;
    c   = ch;
    got = 1'b0;
    r   = '0;
    if (c != slft_pkg::CH_UNDERSCORE) begin
      if (c >= slft_pkg::CH_UA && c <= slft_pkg::CH_UZ) c = c + slft_pkg::CASE_OFFSET;
      k = slft_pkg::KIND_KNOWN;
      if (c == slft_pkg::CH_X) k = slft_pkg::KIND_X;
      else if (c == slft_pkg::CH_Z || c == slft_pkg::CH_QMARK) k = slft_pkg::KIND_Z;
      dv = 16;
      if (c >= slft_pkg::CH_0 && c <= slft_pkg::CH_9) dv = c - slft_pkg::CH_0;
      else if (c >= slft_pkg::CH_LA && c <= slft_pkg::CH_LF)
        dv = c - slft_pkg::CH_LA + 10;
      if (radix_cfg == slft_pkg::RADIX_DEC) begin
        if (ndigits == 0) dec_fill = k;
        if (dv > 9) saw_bad = 1'b1;
        else acc_v = acc_v * 64'd10 + 64'(dv);
      end else begin
        bpd  = (radix_cfg == slft_pkg::RADIX_BIN) ? 1 :
               (radix_cfg == slft_pkg::RADIX_OCT) ? 3 : 4;
        dm   = lowmask(bpd);
        took = 1'b1;
        if (k != slft_pkg::KIND_KNOWN) begin
          acc_v = (acc_v << bpd) | ((k == slft_pkg::KIND_X) ? dm : 64'd0);
          acc_u = (acc_u << bpd) | dm;
        end else if (dv < (1 << bpd)) begin
          acc_v = (acc_v << bpd) | 64'(dv);
          acc_u = acc_u << bpd;
        end else begin
          saw_bad = 1'b1;
          took    = 1'b0;
        end
        if (took) begin
          if (ndigits == 0) lead_kind = k;
          nbits = (nbits + bpd > 127) ? 127 : nbits + bpd;
        end
      end
      if (ndigits < 2) ndigits++;
    end
    if (fin) begin
      w = width_cfg;
      if (w == 0) w = 1;
      if (w > 64) w = 64;
      m   = lowmask(w);
      v   = '0;
      u   = '0;
      bad = 1'b0;
      if (ndigits == 0) begin
        bad = 1'b1;
      end else if (radix_cfg == slft_pkg::RADIX_DEC) begin
        if (ndigits == 1 && dec_fill != slft_pkg::KIND_KNOWN) begin
          u = m;
          v = (dec_fill == slft_pkg::KIND_X) ? m : 64'd0;
        end else if (saw_bad) begin
          bad = 1'b1;
        end else begin
          v = acc_v & m;
        end
      end else if (saw_bad || nbits == 0) begin
        bad = 1'b1;
      end else begin
        v = acc_v & m;
        u = acc_u & m;
        if (nbits < w) begin
          pad = m & ~lowmask(nbits);
          if (lead_kind == slft_pkg::KIND_X) begin
            v = v | pad;
            u = u | pad;
          end else if (lead_kind == slft_pkg::KIND_Z) begin
            u = u | pad;
          end
        end
      end
      if (bad) begin
        v = '0;
        u = '0;
      end
      r   = mk_res(v, u, !bad && u != 64'd0, bad);
      got = 1'b1;
      clear_acc();
    end
  endtask

  // predictor and checker
  always @(posedge clk) begin
    bit       got;
    lit_res_t r;
    lit_res_t e;
    if (!rst_n) begin
      radix_cfg = slft_pkg::RADIX_HEX;
      width_cfg = slft_pkg::TW_RESET;
      clear_acc();
    end else begin
      if (cfg_we) begin
        if (cfg_index == slft_pkg::REG_RADIX) begin
          radix_cfg = slft_pkg::radix_t'(cfg_wdata[1:0]);
        end else begin
          width_cfg = cfg_wdata;
        end
      end
      if (in_tvalid && in_tready) begin
        predict_char(in_tdata, in_tlast, got, r);
        if (got) lit_q.insert(lit_q.size(), drv_typed ? drv_res : r);
      end
      if (out_tvalid && out_tready) begin
        if (lit_q.size() == 0) begin
          $error("result with no request pending: %h", out_tdata);
          err_count++;
        end else begin
          e = lit_q.pop_front();
          if (out_tdata[63:0] !== e.vplane) begin
            $error("value_plane expected %h got %h", e.vplane, out_tdata[63:0]);
            err_count++;
          end
          if (out_tdata[127:64] !== e.uplane) begin
            $error("unknown_plane expected %h got %h", e.uplane, out_tdata[127:64]);
            err_count++;
          end
          if (out_tdata[128] !== e.has_unk) begin
            $error("has_unknown expected %b got %b", e.has_unk, out_tdata[128]);
            err_count++;
          end
          if (out_tdata[129] !== e.bad) begin
            $error("bad_literal expected %b got %b", e.bad, out_tdata[129]);
            err_count++;
          end
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int  hold;
    bit  calm;
    bit  long_done;
    hold       = 0;
    calm       = 1'b0;
    long_done  = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (hold != 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (!long_done && items_sent >= 500) begin
        long_done  = 1'b1;
        hold       = 300;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 30) begin
        hold       = gap_len();
        out_tready <= (hold == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  bit tx_calm;

  task automatic send_item(input logic [7:0] ch, input logic last,
                           input bit typed, input lit_res_t res);
    int g;
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    drv_typed <= typed;
    drv_res   <= res;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if ($urandom_range(0, 149) == 0) tx_calm = !tx_calm;
    g = tx_calm ? 0 : gap_len();
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    repeat (4) @(posedge clk);
    while (lit_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input slft_pkg::reg_idx_t idx, input logic [6:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void push_char(input logic [7:0] ch, input logic last);
    stim_row_t row;
    row.kind  = ROW_CHAR;
    row.ch    = ch;
    row.last  = last;
    row.typed = 1'b0;
    row.res   = '0;
    row.idx   = slft_pkg::REG_RADIX;
    row.wdata = '0;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void push_known(input logic [7:0] ch, input lit_res_t res);
    stim_row_t row;
    row.kind  = ROW_CHAR;
    row.ch    = ch;
    row.last  = 1'b1;
    row.typed = 1'b1;
    row.res   = res;
    row.idx   = slft_pkg::REG_RADIX;
    row.wdata = '0;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void push_cfg(input slft_pkg::reg_idx_t idx, input logic [6:0] val);
    stim_row_t row;
    row.kind  = ROW_CFG;
    row.ch    = '0;
    row.last  = 1'b0;
    row.typed = 1'b0;
    row.res   = '0;
    row.idx   = idx;
    row.wdata = val;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic logic [7:0] rand_case(input logic [7:0] c);
    if (c >= slft_pkg::CH_LA && c <= slft_pkg::CH_Z && $urandom_range(0, 1) == 1)
      return c - slft_pkg::CASE_OFFSET;
    return c;
  endfunction

  task automatic send_literal(input slft_pkg::radix_t rdx, input int w);
    string      unk;
    logic [7:0] chars[$];
    int         bpd;
    int         n;
    int         maxd;
    int         d;
    int         p;
    unk = "xXzZ?";
    if ($urandom_range(0, 99) < 85) begin
      if (rdx == slft_pkg::RADIX_DEC) begin
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 3) == 0) chars.insert(chars.size(), slft_pkg::CH_UNDERSCORE);
          chars.insert(chars.size(), unk[$urandom_range(0, 4)]);
        end else begin
          n = $urandom_range(1, 22);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) chars.insert(chars.size(), slft_pkg::CH_UNDERSCORE);
            chars.insert(chars.size(), slft_pkg::CH_0 + 8'($urandom_range(0, 9)));
          end
        end
      end else begin
        bpd  = (rdx == slft_pkg::RADIX_BIN) ? 1 : (rdx == slft_pkg::RADIX_OCT) ? 3 : 4;
        maxd = w / bpd + 3;
        n    = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 140 / bpd)
                                            : $urandom_range(1, maxd);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 15) == 0) chars.insert(chars.size(), slft_pkg::CH_UNDERSCORE);
          p = (i == 0) ? 25 : 8;
          if ($urandom_range(0, 99) < p) begin
            chars.insert(chars.size(), unk[$urandom_range(0, 4)]);
          end else begin
            d = $urandom_range(0, (1 << bpd) - 1);
            chars.insert(chars.size(), rand_case((d < 10) ? slft_pkg::CH_0 + 8'(d)
                                                          : slft_pkg::CH_LA + 8'(d - 10)));
          end
        end
      end
    end else begin
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) chars.insert(chars.size(), 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) chars.insert(chars.size(), slft_pkg::CH_UNDERSCORE);
      else chars.insert(chars.size(), 8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < chars.size(); i++)
      send_item(chars[i], i == chars.size() - 1, 1'b0, '0);
  endtask

  initial begin
    slft_pkg::radix_t rdx;
    int               wsel;
    int               wreg;
    int               weff;
    int               start;
    items_sent = 0;
    tx_calm    = 1'b0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    drv_typed  <= 1'b0;
    drv_res    <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= slft_pkg::REG_RADIX;
    cfg_wdata  <= '0;

    // directed table; hex, width 32 after reset
    push_known(slft_pkg::CH_UNDERSCORE, mk_res('0, '0, 1'b0, 1'b1));
    push_known("F", mk_res(64'hF, '0, 1'b0, 1'b0));
    push_cfg(slft_pkg::REG_WIDTH, 7'd64);
    push_known("x", mk_res('1, '1, 1'b1, 1'b0));
    push_known("Z", mk_res('0, '1, 1'b1, 1'b0));
    push_char("?", 1'b0);
    push_char("a", 1'b1);
    push_known("g", mk_res('0, '0, 1'b0, 1'b1));
    push_known(8'h00, mk_res('0, '0, 1'b0, 1'b1));
    push_known(8'hFF, mk_res('0, '0, 1'b0, 1'b1));
    push_cfg(slft_pkg::REG_RADIX, 7'(slft_pkg::RADIX_BIN));
    push_cfg(slft_pkg::REG_WIDTH, 7'd1);
    push_char("1", 1'b0);
    push_char("0", 1'b0);
    push_char("1", 1'b1);
    push_known("2", mk_res('0, '0, 1'b0, 1'b1));
    push_cfg(slft_pkg::REG_RADIX, 7'(slft_pkg::RADIX_OCT));
    push_cfg(slft_pkg::REG_WIDTH, 7'd0);
    push_char("7", 1'b1);
    push_cfg(slft_pkg::REG_RADIX, 7'(slft_pkg::RADIX_DEC));
    push_cfg(slft_pkg::REG_WIDTH, 7'd127);
    push_char("9", 1'b0);
    push_char("9", 1'b1);
    push_known("x", mk_res('1, '1, 1'b1, 1'b0));
    push_char("z", 1'b0);
    push_known("1", mk_res('0, '0, 1'b0, 1'b1));
    push_char("1", 1'b0);
    push_known("X", mk_res('0, '0, 1'b0, 1'b1));
    push_char(slft_pkg::CH_UNDERSCORE, 1'b0);
    push_char("5", 1'b1);
    // radix switched between the characters of one literal
    push_cfg(slft_pkg::REG_RADIX, 7'(slft_pkg::RADIX_HEX));
    push_char("1", 1'b0);
    push_cfg(slft_pkg::REG_RADIX, 7'(slft_pkg::RADIX_BIN));
    push_char("1", 1'b1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].wdata);
      end else begin
        send_item(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 4) begin
        rdx  = slft_pkg::radix_t'(ph);
        wsel = ph;
      end else begin
        rdx  = slft_pkg::radix_t'($urandom_range(0, 3));
        wsel = $urandom_range(0, 7);
      end
      case (wsel)
        0:       wreg = 1;
        1:       wreg = 64;
        2:       wreg = 0;
        3:       wreg = 127;
        default: wreg = $urandom_range(1, 64);
      endcase
      weff = (wreg == 0) ? 1 : (wreg > 64) ? 64 : wreg;
      drain();
      write_reg(slft_pkg::REG_RADIX, 7'(rdx));
      write_reg(slft_pkg::REG_WIDTH, 7'(wreg));
      start = items_sent;
      while (items_sent - start < PHASE_LEN) send_literal(rdx, weff);
    end

    drain();
    repeat (10) @(posedge clk);
    if (err_count == 0 && lit_q.size() == 0) begin
      $display("sized_literal_to_four_state verification clean");
    end else begin
      $display("sized_literal_to_four_state verification failed");
    end
    $finish;
  end

endmodule
